// ===== src/fermion_density_row_apply_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fermion density row apply block
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FERMION_DENSITY_ROW_APPLY_TOP_ASSERT_SVH
`define FERMION_DENSITY_ROW_APPLY_TOP_ASSERT_SVH

// same-cycle implication
`define FDRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fdra_pkg.sv =====
// ----------------------------------------------------------------------------
// fdra_pkg
// Shared widths, command codes and the MAC control type of the row apply block.
// ----------------------------------------------------------------------------
package fdra_pkg;

    localparam int WORD_W = 32;
    localparam int CPX_W  = 32;
    localparam int ACC_W  = 48;
    localparam int PROD_W = 66;
    localparam int RND_W  = 36;
    localparam int CNT_W  = 11;
    localparam int SLOT_W = 10;
    localparam int ORB_W  = 6;
    localparam int CMD_W  = 3;

    localparam logic [CMD_W-1:0] CMD_BASIS  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_AMP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TERM   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OFFSET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ROW    = 3'd4;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic rnd_en;
        logic acc_en;
        logic neg;
    } t_mac_ctl;

endpackage

// ===== src/fdra_if.sv =====
// ----------------------------------------------------------------------------
// fdra channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fdra_in_if;
    logic                                  valid;
    logic                                  ready;
    logic        [fdra_pkg::CMD_W-1:0]     cmd;
    logic        [fdra_pkg::SLOT_W-1:0]    slot;
    logic        [fdra_pkg::WORD_W-1:0]    state_word;
    logic        [fdra_pkg::ORB_W-1:0]     orbital;
    logic signed [fdra_pkg::CPX_W-1:0]     real_part;
    logic signed [fdra_pkg::CPX_W-1:0]     imag_part;

    modport source (output valid, cmd, slot, state_word, orbital, real_part, imag_part,
                    input ready);
    modport sink   (input valid, cmd, slot, state_word, orbital, real_part, imag_part,
                    output ready);
endinterface

interface fdra_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fdra_pkg::ACC_W-1:0]     value_re;
    logic signed [fdra_pkg::ACC_W-1:0]     value_im;
    logic                                  is_row_value;

    modport source (output valid, value_re, value_im, is_row_value, input ready);
    modport sink   (input valid, value_re, value_im, is_row_value, output ready);
endinterface

// ===== src/fdra_mac.sv =====
// ----------------------------------------------------------------------------
// fdra_mac
// Complex multiply, sign, Q.30 rounding and saturating Q17.30 accumulate.
// ----------------------------------------------------------------------------
module fdra_mac (
    input  logic                                i_clk,
    input  fdra_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [fdra_pkg::CPX_W-1:0]   i_cr,
    input  logic signed [fdra_pkg::CPX_W-1:0]   i_ci,
    input  logic signed [fdra_pkg::CPX_W-1:0]   i_ar,
    input  logic signed [fdra_pkg::CPX_W-1:0]   i_ai,
    output logic signed [fdra_pkg::ACC_W-1:0]   o_acc_re,
    output logic signed [fdra_pkg::ACC_W-1:0]   o_acc_im
);

    localparam int PW = 2 * fdra_pkg::CPX_W;

    logic signed [PW-1:0]                 r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [fdra_pkg::RND_W-1:0]    r_rnd_re, r_rnd_im;
    logic signed [fdra_pkg::ACC_W-1:0]    r_acc_re, r_acc_im;
    logic signed [fdra_pkg::PROD_W-1:0]   sum_re, sum_im, sgn_re, sgn_im, bias_re, bias_im;

    function automatic logic signed [fdra_pkg::ACC_W-1:0] sat_add(
        input logic signed [fdra_pkg::ACC_W-1:0] a,
        input logic signed [fdra_pkg::RND_W-1:0] b
    );
        logic signed [fdra_pkg::ACC_W:0] s;
        s = {a[fdra_pkg::ACC_W-1], a} +
            {{(fdra_pkg::ACC_W + 1 - fdra_pkg::RND_W){b[fdra_pkg::RND_W-1]}}, b};
        if (s[fdra_pkg::ACC_W] != s[fdra_pkg::ACC_W-1]) begin
            sat_add = s[fdra_pkg::ACC_W] ? {1'b1, {(fdra_pkg::ACC_W-1){1'b0}}}
                                         : {1'b0, {(fdra_pkg::ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[fdra_pkg::ACC_W-1:0];
        end
    endfunction

    always_comb begin
        sum_re  = {{(fdra_pkg::PROD_W-PW){r_p_rr[PW-1]}}, r_p_rr}
                - {{(fdra_pkg::PROD_W-PW){r_p_ii[PW-1]}}, r_p_ii};
        sum_im  = {{(fdra_pkg::PROD_W-PW){r_p_ri[PW-1]}}, r_p_ri}
                + {{(fdra_pkg::PROD_W-PW){r_p_ir[PW-1]}}, r_p_ir};
        sgn_re  = i_ctl.neg ? -sum_re : sum_re;
        sgn_im  = i_ctl.neg ? -sum_im : sum_im;
        // add half an LSB, then the arithmetic shift floors
        bias_re = sgn_re + fdra_pkg::PROD_W'(32'h2000_0000);
        bias_im = sgn_im + fdra_pkg::PROD_W'(32'h2000_0000);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_p_rr <= i_cr * i_ar;
            r_p_ii <= i_ci * i_ai;
            r_p_ri <= i_cr * i_ai;
            r_p_ir <= i_ci * i_ar;
        end
        if (i_ctl.rnd_en) begin
            r_rnd_re <= bias_re[fdra_pkg::PROD_W-1:30];
            r_rnd_im <= bias_im[fdra_pkg::PROD_W-1:30];
        end
        if (i_ctl.clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc_re <= sat_add(r_acc_re, r_rnd_re);
            r_acc_im <= sat_add(r_acc_im, r_rnd_im);
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

// ===== src/fermion_density_row_apply_top.sv =====
// ----------------------------------------------------------------------------
// fermion_density_row_apply_top
// Fermionic one-body operator row: table loads and fixed-point row compute.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one transaction per item: cmd 0..3 load the basis, amplitude,
//   term and offset tables, cmd 4 computes one row for state_word; other codes
//   only acknowledge. o_out returns exactly one transaction per item.
//   i_cfg_we/i_cfg_wdata write basis_count, the number of basis entries searched.
// Sequencing:
//   A load's acknowledge is registered in the output register in the cycle
//   after it is taken. A row scans the orbitals and, per occupied orbital,
//   its terms; each term that is not skipped searches the basis. The search walks
//   the basis memory one entry per cycle up to the first match or to
//   basis_count (at most BASIS_DEPTH); this linear scan dominates row time.
//   One item is in work at a time.
// Reset:
//   Control state and basis_count clear; the tables hold garbage until loaded.
// Stall:
//   A result waits in the output register; a new item is taken in the cycle
//   the waiting result is taken, and otherwise held off.
// ----------------------------------------------------------------------------
`include "fermion_density_row_apply_top_assert.svh"

module fermion_density_row_apply_top #(
    parameter int ORBITALS    = 32,
    parameter int BASIS_DEPTH = 1024,
    parameter int TERM_DEPTH  = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fdra_in_if.sink                           i_in,
    fdra_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [fdra_pkg::CNT_W-1:0]        i_cfg_wdata
);

    localparam int BI_W  = $clog2(BASIS_DEPTH > 1 ? BASIS_DEPTH : 2);
    localparam int IDX_W = $clog2(BASIS_DEPTH + 1);
    localparam int TI_W  = $clog2(TERM_DEPTH > 1 ? TERM_DEPTH : 2);
    localparam int OFF_W = $clog2(TERM_DEPTH + 1);
    localparam int OI_W  = $clog2(ORBITALS + 1);
    localparam int OLIM  = ORBITALS < fdra_pkg::WORD_W ? ORBITALS : fdra_pkg::WORD_W;
    localparam int W     = fdra_pkg::WORD_W;
    localparam int CW    = fdra_pkg::CPX_W;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_ORB  = 9'b000000010,
        ST_OFFW = 9'b000000100,
        ST_TERM = 9'b000001000,
        ST_TRD  = 9'b000010000,
        ST_SRCH = 9'b000100000,
        ST_AMP  = 9'b001000000,
        ST_MUL  = 9'b010000000,
        ST_ACC  = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [fdra_pkg::ORB_W-1:0] orb;
        logic signed [CW-1:0]       cre;
        logic signed [CW-1:0]       cim;
    } t_term;

    typedef struct packed {
        logic signed [CW-1:0] re;
        logic signed [CW-1:0] im;
    } t_amp;

    // memories
    logic [W-1:0]     basis_mem [BASIS_DEPTH];
    t_amp             amp_mem   [BASIS_DEPTH];
    t_term            term_mem  [TERM_DEPTH];
    logic [OFF_W-1:0] off_mem   [ORBITALS+1];

    logic [W-1:0]     rd_basis;
    t_amp             rd_amp;
    t_term            rd_term;
    logic [OFF_W-1:0] rd_lo, rd_hi;

    t_state                     r_state;
    logic [fdra_pkg::CNT_W-1:0] r_bcount;
    logic [W-1:0]               r_word, r_src;
    logic [OI_W-1:0]            r_o;
    logic [OFF_W-1:0]           r_loc, r_hi;
    logic [IDX_W-1:0]           r_idx;
    logic [BI_W-1:0]            r_cidx;
    logic                       r_pend, r_neg;
    logic signed [CW-1:0]       r_cr, r_ci;
    logic                       r_ovalid, r_orow;
    logic signed [fdra_pkg::ACC_W-1:0] r_ore, r_oim;

    logic                       accept, is_load, finish;
    logic [IDX_W-1:0]           n_lim;
    logic [OI_W-1:0]            hi_addr;
    logic [W-1:0]               o_bit, below_o, t_bit, src0;
    logic                       t_skip, t_neg;
    logic [fdra_pkg::ORB_W-1:0] t_orb;
    logic                       we_basis, we_amp, we_term, we_off;
    fdra_pkg::t_mac_ctl         mac_ctl;
    logic signed [fdra_pkg::ACC_W-1:0] acc_re, acc_im;

    assign i_in.ready = (r_state == ST_IDLE) && (!r_ovalid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;
    assign is_load    = i_in.cmd != fdra_pkg::CMD_ROW;
    assign finish     = (r_state == ST_ORB) && (32'(r_o) >= OLIM);

    assign we_basis = accept && i_in.cmd == fdra_pkg::CMD_BASIS
                      && 32'(i_in.slot) < BASIS_DEPTH;
    assign we_amp   = accept && i_in.cmd == fdra_pkg::CMD_AMP
                      && 32'(i_in.slot) < BASIS_DEPTH;
    assign we_term  = accept && i_in.cmd == fdra_pkg::CMD_TERM
                      && 32'(i_in.slot) < TERM_DEPTH;
    assign we_off   = accept && i_in.cmd == fdra_pkg::CMD_OFFSET
                      && 32'(i_in.orbital) <= ORBITALS;

    assign n_lim   = (32'(r_bcount) > BASIS_DEPTH) ? IDX_W'(BASIS_DEPTH) : IDX_W'(r_bcount);
    assign hi_addr = (32'(r_o) >= OLIM) ? r_o : r_o + 1'b1;

    // term decode: annihilate orbital o, create orbital to
    always_comb begin
        t_orb   = rd_term.orb;
        o_bit   = W'(1) << r_o;
        below_o = o_bit - W'(1);
        t_bit   = W'(1) << t_orb;
        src0    = r_word & ~o_bit;
        // creation above the stored word width can never match a basis word
        t_skip  = (32'(t_orb) >= ORBITALS) || (32'(t_orb) >= W) || (|(src0 & t_bit));
        t_neg   = (^(r_word & below_o)) ^ (^(src0 & (t_bit - W'(1))));
    end

    always_ff @(posedge i_clk) begin
        if (we_basis) begin
            basis_mem[BI_W'(i_in.slot)] <= i_in.state_word;
        end
        rd_basis <= basis_mem[r_idx[BI_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_amp) begin
            amp_mem[BI_W'(i_in.slot)] <= '{re: i_in.real_part, im: i_in.imag_part};
        end
        rd_amp <= amp_mem[r_cidx];
    end

    always_ff @(posedge i_clk) begin
        if (we_term) begin
            term_mem[TI_W'(i_in.slot)] <= '{orb: i_in.orbital, cre: i_in.real_part,
                                            cim: i_in.imag_part};
        end
        rd_term <= term_mem[r_loc[TI_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_off) begin
            off_mem[OI_W'(i_in.orbital)] <= (32'(i_in.slot) > TERM_DEPTH)
                                            ? OFF_W'(TERM_DEPTH) : OFF_W'(i_in.slot);
        end
        rd_lo <= off_mem[r_o];
        rd_hi <= off_mem[hi_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount <= '0;
        end else if (i_cfg_we) begin
            r_bcount <= i_cfg_wdata;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_o     <= '0;
            r_loc   <= '0;
            r_idx   <= '0;
            r_cidx  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && !is_load) begin
                        r_word  <= i_in.state_word;
                        r_o     <= '0;
                        r_state <= ST_ORB;
                    end
                end
                ST_ORB: begin
                    if (finish) begin
                        r_state <= ST_IDLE;
                    end else if (|(r_word & (W'(1) << r_o))) begin
                        r_state <= ST_OFFW;
                    end else begin
                        r_o <= r_o + 1'b1;
                    end
                end
                ST_OFFW: begin
                    r_loc   <= rd_lo;
                    r_hi    <= rd_hi;
                    r_state <= ST_TERM;
                end
                ST_TERM: begin
                    if (r_loc < r_hi && 32'(r_loc) < TERM_DEPTH) begin
                        r_state <= ST_TRD;
                    end else begin
                        r_o     <= r_o + 1'b1;
                        r_state <= ST_ORB;
                    end
                end
                ST_TRD: begin
                    if (t_skip) begin
                        r_loc   <= r_loc + 1'b1;
                        r_state <= ST_TERM;
                    end else begin
                        r_src   <= src0 | t_bit;
                        r_neg   <= t_neg;
                        r_cr    <= rd_term.cre;
                        r_ci    <= rd_term.cim;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    // compare last read while the next address goes out
                    if (r_pend && rd_basis == r_src) begin
                        r_pend  <= 1'b0;
                        r_state <= ST_AMP;
                    end else if (r_idx < n_lim) begin
                        r_cidx <= r_idx[BI_W-1:0];
                        r_pend <= 1'b1;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_loc   <= r_loc + 1'b1;
                        r_state <= ST_TERM;
                    end
                end
                ST_AMP: r_state <= ST_MUL;
                ST_MUL: r_state <= ST_ACC;
                ST_ACC: begin
                    r_loc   <= r_loc + 1'b1;
                    r_state <= ST_TERM;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        mac_ctl        = '0;
        mac_ctl.clr    = accept && !is_load;
        mac_ctl.mul_en = r_state == ST_AMP;
        mac_ctl.rnd_en = r_state == ST_MUL;
        mac_ctl.acc_en = r_state == ST_ACC;
        mac_ctl.neg    = r_neg;
    end

    fdra_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_cr     (r_cr),
        .i_ci     (r_ci),
        .i_ar     (rd_amp.re),
        .i_ai     (rd_amp.im),
        .o_acc_re (acc_re),
        .o_acc_im (acc_im)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept && is_load) begin
            r_ovalid <= 1'b1;
            r_ore    <= '0;
            r_oim    <= '0;
            r_orow   <= 1'b0;
        end else if (finish) begin
            r_ovalid <= 1'b1;
            r_ore    <= acc_re;
            r_oim    <= acc_im;
            r_orow   <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.value_re     = r_ore;
    assign o_out.value_im     = r_oim;
    assign o_out.is_row_value = r_orow;

    `FDRA_ASSERT_NOW(a_finish_free, finish, !r_ovalid, "row result would overwrite a pending result")
    `FDRA_ASSERT_NOW(a_srch_bound, r_state == ST_SRCH, r_idx <= n_lim, "basis scan ran past basis_count")
    `FDRA_ASSERT_NEXT(a_load_ack, accept && is_load, o_out.valid && !o_out.is_row_value, "load not acknowledged")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb - fermion density row apply regression
// Loads the basis, amplitude, term and offset tables, then checks row results
// and load acknowledges against a bit-accurate predictor of the fixed-point
// one-body operator row, under bursty input and stalling output.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fdra_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [fdra_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
    localparam int N_ORB    = 32;
    localparam int N_BASIS  = 1024;
    localparam int N_TERM   = 256;
    localparam int LOW_SETS = 64;   // basis/amplitude slots with live data
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -64'sh0000_8000_0000_0000;
    localparam logic [31:0] NO_MATCH_WORD = 32'hFFFF_FFFF;

    typedef struct {
        logic [fdra_pkg::CMD_W-1:0]         cmd;
        logic [fdra_pkg::SLOT_W-1:0]        slot;
        logic [fdra_pkg::WORD_W-1:0]        word;
        logic [fdra_pkg::ORB_W-1:0]         orb;
        logic signed [fdra_pkg::CPX_W-1:0]  re;
        logic signed [fdra_pkg::CPX_W-1:0]  im;
    } t_item;

    typedef struct {
        logic signed [fdra_pkg::ACC_W-1:0] re;
        logic signed [fdra_pkg::ACC_W-1:0] im;
        logic                              is_row;
    } t_row_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [fdra_pkg::CNT_W-1:0] i_cfg_wdata;

    fdra_in_if  in_ch ();
    fdra_out_if out_ch ();

    fermion_density_row_apply_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mirror of the block's tables
    logic [31:0]        basis_m  [N_BASIS];
    logic signed [31:0] amp_re_m [N_BASIS];
    logic signed [31:0] amp_im_m [N_BASIS];
    logic [5:0]         torb_m   [N_TERM];
    logic signed [31:0] coef_re_m[N_TERM];
    logic signed [31:0] coef_im_m[N_TERM];
    int                 offs_m   [N_ORB + 1];
    int                 search_count;

    t_item       pend_q[$];
    t_row_result row_exp_q[$];
    logic [31:0] pool[8];

    int errors = 0;
    int n_rows = 0;
    int n_acks = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_cnt = 0;
    int rx_cyc = 0;
    int rx_mode = 0;
    bit hold_req = 0;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic int low_parity(logic [31:0] w, int pos);
        return $countones(w & ((32'd1 << pos) - 32'd1)) & 1;
    endfunction

    function automatic t_row_result apply_item(t_item it);
        t_row_result        r;
        longint             acc_re, acc_im, rr, ri;
        logic signed [65:0] pr, pi;
        logic signed [31:0] cr, ci, ar, ai;
        logic [31:0]        src;
        int                 lo, hi, to, idx, lim, neg;
        r.re = '0;
        r.im = '0;
        r.is_row = 1'b0;
        case (it.cmd)
            fdra_pkg::CMD_BASIS: basis_m[it.slot] = it.word;
            fdra_pkg::CMD_AMP: begin
                amp_re_m[it.slot] = it.re;
                amp_im_m[it.slot] = it.im;
            end
            fdra_pkg::CMD_TERM: begin
                if (it.slot < N_TERM) begin
                    torb_m[it.slot]    = it.orb;
                    coef_re_m[it.slot] = it.re;
                    coef_im_m[it.slot] = it.im;
                end
            end
            fdra_pkg::CMD_OFFSET: begin
                if (it.orb <= N_ORB)
                    offs_m[it.orb] = (it.slot > N_TERM) ? N_TERM : int'(it.slot);
            end
            fdra_pkg::CMD_ROW: begin
                acc_re = 0;
                acc_im = 0;
                lim = (search_count > N_BASIS) ? N_BASIS : search_count;
                for (int o = 0; o < N_ORB; o++) begin
                    if (!it.word[o]) continue;
                    lo = offs_m[o];
                    hi = offs_m[o + 1];
                    for (int loc = lo; loc < hi && loc < N_TERM; loc++) begin
                        to = torb_m[loc];
                        if (to >= N_ORB) continue;
                        neg = low_parity(it.word, o);
                        src = it.word & ~(32'd1 << o);
                        if (src[to]) continue;
                        neg ^= low_parity(src, to);
                        src |= 32'd1 << to;
                        idx = -1;
                        for (int i = 0; i < lim; i++) begin
                            if (basis_m[i] == src) begin
                                idx = i;
                                break;
                            end
                        end
                        if (idx < 0) continue;
                        cr = coef_re_m[loc];
                        ci = coef_im_m[loc];
                        ar = amp_re_m[idx];
                        ai = amp_im_m[idx];
                        pr = cr * ar - ci * ai;
                        pi = cr * ai + ci * ar;
                        if (neg != 0) begin
                            pr = -pr;
                            pi = -pi;
                        end
                        rr = longint'((pr + 66'sd536870912) >>> 30);
                        ri = longint'((pi + 66'sd536870912) >>> 30);
                        acc_re = acc_re + rr;
                        acc_im = acc_im + ri;
                        if (acc_re > ACC_HI) acc_re = ACC_HI;
                        if (acc_re < ACC_LO) acc_re = ACC_LO;
                        if (acc_im > ACC_HI) acc_im = ACC_HI;
                        if (acc_im < ACC_LO) acc_im = ACC_LO;
                    end
                end
                r.re = acc_re[47:0];
                r.im = acc_im[47:0];
                r.is_row = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                row_exp_q.push_back(apply_item(pend_q.pop_front()));
            if (in_ch.valid && !in_ch.ready) begin
                // hold the offered transaction
            end else if (gap_left > 0 || pend_q.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                in_ch.valid      <= 1'b1;
                in_ch.cmd        <= pend_q[0].cmd;
                in_ch.slot       <= pend_q[0].slot;
                in_ch.state_word <= pend_q[0].word;
                in_ch.orbital    <= pend_q[0].orb;
                in_ch.real_part  <= pend_q[0].re;
                in_ch.imag_part  <= pend_q[0].im;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                             : $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: stall pattern of its own plus one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt--;
        end else if (hold_req) begin
            out_ch.ready <= 1'b0;
            hold_cnt = 400;
            hold_req = 0;
        end else begin
            rx_cyc++;
            if (rx_cyc % 100 == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= $urandom_range(0, 1);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_row_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (row_exp_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction re=%0d im=%0d row=%0b", $realtime,
                         out_ch.value_re, out_ch.value_im, out_ch.is_row_value);
            end else begin
                e = row_exp_q.pop_front();
                if (e.is_row) n_rows++; else n_acks++;
                if (out_ch.value_re !== e.re) begin
                    errors++;
                    $display("%0t: value_re expected %0d actual %0d", $realtime,
                             e.re, out_ch.value_re);
                end
                if (out_ch.value_im !== e.im) begin
                    errors++;
                    $display("%0t: value_im expected %0d actual %0d", $realtime,
                             e.im, out_ch.value_im);
                end
                if (out_ch.is_row_value !== e.is_row) begin
                    errors++;
                    $display("%0t: is_row_value expected %0b actual %0b", $realtime,
                             e.is_row, out_ch.is_row_value);
                end
            end
        end
    end

    task automatic push(logic [fdra_pkg::CMD_W-1:0] cmd, int slot, logic [31:0] word,
                        int orb, logic [31:0] re, logic [31:0] im);
        t_item it;
        it.cmd  = cmd;
        it.slot = slot[fdra_pkg::SLOT_W-1:0];
        it.word = word;
        it.orb  = orb[fdra_pkg::ORB_W-1:0];
        it.re   = re;
        it.im   = im;
        pend_q.push_back(it);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pend_q.size() != 0 || row_exp_q.size() != 0 || in_ch.valid);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_count(int v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[fdra_pkg::CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        search_count = v;
    endtask

    // move one electron: clear an occupied bit, set an empty one
    function automatic logic [31:0] hop(logic [31:0] w);
        int a, b;
        if (w == 32'd0 || w == NO_MATCH_WORD) return w;
        do a = $urandom_range(0, 31); while (!w[a]);
        do b = $urandom_range(0, 31); while (w[b]);
        w[a] = 1'b0;
        w[b] = 1'b1;
        return w;
    endfunction

    function automatic logic [31:0] wide_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_random();
        int sel, orb, v;
        sel = $urandom_range(0, 99);
        if (sel < 36) begin
            case ($urandom_range(0, 9))
                0: push(fdra_pkg::CMD_ROW, $urandom, $urandom, $urandom, $urandom, $urandom);
                1: push(fdra_pkg::CMD_ROW, $urandom, hop(pool[$urandom_range(0, 7)]),
                        $urandom, $urandom, $urandom);
                default: push(fdra_pkg::CMD_ROW, $urandom, pool[$urandom_range(0, 7)],
                              $urandom, $urandom, $urandom);
            endcase
        end else if (sel < 56) begin
            if ($urandom_range(0, 4) == 0)
                push(fdra_pkg::CMD_BASIS, $urandom_range(0, N_BASIS - 1), $urandom,
                     $urandom, $urandom, $urandom);
            else
                push(fdra_pkg::CMD_BASIS, $urandom_range(0, LOW_SETS - 1),
                     hop(pool[$urandom_range(0, 7)]), $urandom, $urandom, $urandom);
        end else if (sel < 70) begin
            push(fdra_pkg::CMD_AMP, $urandom, $urandom, $urandom, wide_value(), wide_value());
        end else if (sel < 84) begin
            orb = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 31);
            push(fdra_pkg::CMD_TERM,
                 ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 63),
                 $urandom, orb, wide_value(), wide_value());
        end else if (sel < 97) begin
            // keep term ranges short so rows stay quick
            orb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
            v = (orb >= 1 && orb <= N_ORB) ? offs_m[orb - 1] + $urandom_range(0, 4)
                                           : $urandom_range(0, 1023);
            if ($urandom_range(0, 24) == 0) v = $urandom_range(0, 127);
            if (v > 1023) v = 1023;
            push(fdra_pkg::CMD_OFFSET, v, $urandom, orb, $urandom, $urandom);
        end else begin
            push($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST), $urandom, $urandom,
                 $urandom, $urandom, $urandom);
        end
    endtask

    task automatic random_phase(int count, int n_items, bit long_hold);
        for (int i = 0; i < 8; i++) begin
            pool[i] = $urandom;
            if (i >= 4) pool[i] &= $urandom;
        end
        write_count(count);
        for (int i = 0; i < n_items; i++) push_random();
        if (long_hold) hold_req = 1;
        drain();
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.cmd        = fdra_pkg::CMD_BASIS;
        in_ch.slot       = '0;
        in_ch.state_word = '0;
        in_ch.orbital    = '0;
        in_ch.real_part  = '0;
        in_ch.imag_part  = '0;
        out_ch.ready     = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        search_count     = 0;
        i_rst_n          = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every table that a row can read
        write_count(0);
        for (int o = 0; o <= N_ORB; o++)
            push(fdra_pkg::CMD_OFFSET, 2 * o, $urandom, o, $urandom, $urandom);
        for (int t = 0; t < N_TERM; t++)
            push(fdra_pkg::CMD_TERM, t, $urandom, $urandom_range(0, 31), wide_value(),
                 wide_value());
        for (int s = 0; s < LOW_SETS; s++) begin
            push(fdra_pkg::CMD_BASIS, s, NO_MATCH_WORD, $urandom, $urandom, $urandom);
            push(fdra_pkg::CMD_AMP, s, $urandom, $urandom, wide_value(), wide_value());
        end
        push(fdra_pkg::CMD_ROW, 0, 32'h8000_0003, 0, 0, 0);
        push(fdra_pkg::CMD_ROW, 0, 32'h0F0F_0F0F, 0, 0, 0);
        drain();

        // directed corner cases
        write_count(LOW_SETS);
        push(fdra_pkg::CMD_TERM, 0, 0, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push(fdra_pkg::CMD_TERM, 1, 0, 1, 32'h8000_0000, 32'h8000_0000); // creation into occupied
        push(fdra_pkg::CMD_TERM, 2, 0, 40, $urandom, $urandom);          // orbital out of range
        push(fdra_pkg::CMD_TERM, 3, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        push(fdra_pkg::CMD_BASIS, 0, 32'h8000_0006, 0, 0, 0);
        push(fdra_pkg::CMD_BASIS, 1, 32'h8000_0006, 0, 0, 0);            // duplicate word
        push(fdra_pkg::CMD_AMP, 0, 0, 0, 32'h8000_0000, 32'h8000_0000);
        push(fdra_pkg::CMD_AMP, 1, 0, 0, 32'h7FFF_FFFF, 32'h0);
        push(fdra_pkg::CMD_OFFSET, 40, 0, 31, 0, 0);
        push(fdra_pkg::CMD_ROW, 0, 32'h8000_0003, 0, 0, 0);
        push(fdra_pkg::CMD_ROW, 0, 32'h0000_0000, 0, 0, 0);
        push(fdra_pkg::CMD_ROW, 1023, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(fdra_pkg::CMD_ROW, 0, 32'h0000_0010, 0, 0, 0);              // likely word not found
        push(fdra_pkg::CMD_OFFSET, 5, 0, 33, 0, 0);                      // orbital beyond range
        push(fdra_pkg::CMD_OFFSET, 1023, 0, 63, 0, 0);
        push(fdra_pkg::CMD_OFFSET, 1023, 0, 30, 0, 0);                   // saturates to term depth
        push(fdra_pkg::CMD_TERM, 1023, 0, 5, 0, 0);                      // slot beyond term depth
        push(fdra_pkg::CMD_ROW, 0, 32'h2000_0001, 0, 0, 0);
        push(fdra_pkg::CMD_OFFSET, 0, 0, 32, 0, 0);                      // reversed range
        push(fdra_pkg::CMD_ROW, 0, 32'h8000_0000, 0, 0, 0);
        push(CMD_SPARE_FIRST, 1023, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(CMD_SPARE_LAST, 0, 0, 0, 0, 0);
        push(fdra_pkg::CMD_OFFSET, 60, 0, 30, 0, 0);
        push(fdra_pkg::CMD_OFFSET, 64, 0, 32, 0, 0);
        drain();

        random_phase(LOW_SETS, 100, 1'b1);
        random_phase(1, 70, 1'b0);
        random_phase(33, 80, 1'b0);
        random_phase($urandom_range(2, LOW_SETS), 80, 1'b0);
        random_phase(LOW_SETS, 70, 1'b0);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d row results and %0d load acknowledges", n_rows, n_acks);
        $display("basis_count ran from 0 through 64, with stalls and bursts");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #1s;
        $display("Timeout with %0d transactions outstanding", row_exp_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
